// ===== hdl/m4rm_pkg.sv =====
// ----------------------------------------------------------------------------
// m4rm_pkg
// Shared types and constants of the 4x4 fixed-point row multiply unit.
// ----------------------------------------------------------------------------
package m4rm_pkg;

   // matrix size and fixed-point format
   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;

   localparam int ELEM_W = 32;
   localparam int ROW_W  = $clog2(DIM);
   localparam int PROD_W = 2 * ELEM_W;
   // exact sum of DIM full products
   localparam int SUM_W  = PROD_W + $clog2(DIM);

   localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_MULT = 1'b1
   } req_kind_type;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;

endpackage

// ===== hdl/m4rm_req_if.sv =====
// ----------------------------------------------------------------------------
// m4rm_req_if
// Request channel: a load row or a multiply row with its row number.
// ----------------------------------------------------------------------------
interface m4rm_req_if;
   import m4rm_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [ROW_W-1:0]    row_index;
   logic signed [ELEM_W-1:0] in_elem0;
   logic signed [ELEM_W-1:0] in_elem1;
   logic signed [ELEM_W-1:0] in_elem2;
   logic signed [ELEM_W-1:0] in_elem3;

   modport source (
      output valid, req_type, row_index, in_elem0, in_elem1, in_elem2, in_elem3,
      input  ready
   );

   modport sink (
      input  valid, req_type, row_index, in_elem0, in_elem1, in_elem2, in_elem3,
      output ready
   );

endinterface

// ===== hdl/m4rm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// m4rm_rsp_if
// Response channel: one saturated product row and its clip flag.
// ----------------------------------------------------------------------------
interface m4rm_rsp_if;
   import m4rm_pkg::*;

   logic                valid;
   logic                ready;
   logic [ROW_W-1:0]    out_row;
   logic signed [ELEM_W-1:0] out_elem0;
   logic signed [ELEM_W-1:0] out_elem1;
   logic signed [ELEM_W-1:0] out_elem2;
   logic signed [ELEM_W-1:0] out_elem3;
   logic                saturated;

   modport source (
      output valid, out_row, out_elem0, out_elem1, out_elem2, out_elem3, saturated,
      input  ready
   );

   modport sink (
      input  valid, out_row, out_elem0, out_elem1, out_elem2, out_elem3, saturated,
      output ready
   );

endinterface

// ===== hdl/m4rm_col_reduce.sv =====
// ----------------------------------------------------------------------------
// m4rm_col_reduce
// Sums one column's full products, scales by the fraction bits and
// saturates the result to the element width.
// ----------------------------------------------------------------------------
module m4rm_col_reduce (
   input  m4rm_pkg::prod_type prods [m4rm_pkg::DIM],
   output m4rm_pkg::elem_type result,
   output logic               clip
);
   import m4rm_pkg::*;

   logic signed [SUM_W-1:0]    sum;
   logic signed [SUM_W-1:0]    shifted;
   logic [SUM_W-ELEM_W:0]      upper;
   logic                       fits;

   always_comb begin
      sum = '0;
      for (int k = 0; k < DIM; k++) begin
         sum = sum + SUM_W'(prods[k]);
      end
   end

   // arithmetic shift truncates toward minus infinity
   assign shifted = sum >>> FRAC_BITS;
   assign upper   = shifted[SUM_W-1:ELEM_W-1];
   assign fits    = (&upper) || !(|upper);
   assign clip    = !fits;

   always_comb begin
      if (fits) begin
         result = shifted[ELEM_W-1:0];
      end else if (sum[SUM_W-1]) begin
         result = ELEM_MIN;
      end else begin
         result = ELEM_MAX;
      end
   end

endmodule

// ===== hdl/matrix4_row_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// matrix4_row_multiply_unit
// Row times stored 4x4 matrix in signed Q16.16, saturated to 32 bits.
// ----------------------------------------------------------------------------
// Takes one request per clock while the input register is not stalled. A load
// request writes one row of the stored right-hand matrix when it leaves the
// input register and gives no response; a multiply request that follows it,
// even in the next cycle, already sees the new row. A multiply request passes
// in order through the input register, a product register fed by sixteen
// 32x32 signed multipliers working in parallel (one per matrix element), and
// the response register fed by the per-column sum, shift and saturation. Each
// stage holds one row and stalls only when the stage after it is full, so a
// waiting response blocks new requests only once a multiply is held in the
// input register behind a full product stage. Stored rows have no reset;
// multiply only after every row of the right matrix has been loaded.
// ----------------------------------------------------------------------------
module matrix4_row_multiply_unit (
   input  logic       clock,
   input  logic       reset,
   m4rm_req_if.sink   req_if,
   m4rm_rsp_if.source rsp_if
);
   import m4rm_pkg::*;

   // input stage
   logic              in_valid_ff, in_valid_in;
   req_kind_type      in_kind_ff;
   logic [ROW_W-1:0]  in_row_ff;
   elem_type          in_elem_ff [DIM];

   // stored right-hand matrix, row-major
   elem_type          mat_ff [DIM][DIM];

   // product stage
   logic              prod_valid_ff, prod_valid_in;
   logic [ROW_W-1:0]  prod_row_ff;
   prod_type          prod_in [DIM][DIM];
   prod_type          prod_ff [DIM][DIM];

   // response stage
   logic              out_valid_ff, out_valid_in;
   logic [ROW_W-1:0]  out_row_ff;
   elem_type          out_elem_ff [DIM];
   logic              out_sat_ff;

   elem_type          col_res [DIM];
   logic [DIM-1:0]    col_clip;
   prod_type          col_prods [DIM][DIM];

   logic              in_accept;
   logic              in_done;
   logic              prod_adv;
   logic              out_adv;

   // ---------------- handshake ----------------
   assign out_adv   = !out_valid_ff || rsp_if.ready;
   assign prod_adv  = !prod_valid_ff || out_adv;
   // loads retire from the input register on their own
   assign in_done   = in_valid_ff && ((in_kind_ff == REQ_LOAD) || prod_adv);
   assign req_if.ready = !in_valid_ff || in_done;
   assign in_accept = req_if.valid && req_if.ready;

   assign in_valid_in   = in_accept || (in_valid_ff && !in_done);
   assign prod_valid_in = prod_adv ? (in_valid_ff && (in_kind_ff == REQ_MULT))
                                   : prod_valid_ff;
   assign out_valid_in  = out_adv ? prod_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // ---------------- input register ----------------
   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_kind_ff    <= req_kind_type'(req_if.req_type);
         in_row_ff     <= req_if.row_index;
         in_elem_ff[0] <= req_if.in_elem0;
         in_elem_ff[1] <= req_if.in_elem1;
         in_elem_ff[2] <= req_if.in_elem2;
         in_elem_ff[3] <= req_if.in_elem3;
      end
   end

   // row_index always addresses a row, so every load writes
   always_ff @(posedge clock) begin
      if (in_valid_ff && (in_kind_ff == REQ_LOAD)) begin
         mat_ff[in_row_ff] <= in_elem_ff;
      end
   end

   // ---------------- products ----------------
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         for (int j = 0; j < DIM; j++) begin
            prod_in[k][j] = in_elem_ff[k] * mat_ff[k][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_adv) begin
         prod_row_ff <= in_row_ff;
         prod_ff     <= prod_in;
      end
   end

   // ---------------- column sums ----------------
   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         for (int k = 0; k < DIM; k++) begin
            col_prods[j][k] = prod_ff[k][j];
         end
      end
   end

   for (genvar j = 0; j < DIM; j++) begin : g_col
      m4rm_col_reduce u_col_reduce (
         .prods  (col_prods[j]),
         .result (col_res[j]),
         .clip   (col_clip[j])
      );
   end

   always_ff @(posedge clock) begin
      if (out_adv && prod_valid_ff) begin
         out_row_ff  <= prod_row_ff;
         out_elem_ff <= col_res;
         out_sat_ff  <= |col_clip;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_row   = out_row_ff;
   assign rsp_if.out_elem0 = out_elem_ff[0];
   assign rsp_if.out_elem1 = out_elem_ff[1];
   assign rsp_if.out_elem2 = out_elem_ff[2];
   assign rsp_if.out_elem3 = out_elem_ff[3];
   assign rsp_if.saturated = out_sat_ff;

`ifndef SYNTH
   // a stalled multiply stays in the input register
   a_mult_held : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (in_kind_ff == REQ_MULT) && !prod_adv
      |=> in_valid_ff && (in_kind_ff == REQ_MULT) && $stable(in_row_ff))
      else $error("stalled multiply request lost from input stage");

   // a load never blocks the request side
   a_load_retires : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (in_kind_ff == REQ_LOAD) |-> req_if.ready)
      else $error("load request did not retire");

   // product row is kept while the response register is full and waiting
   a_prod_held : assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff && !out_adv |=> prod_valid_ff && $stable(prod_row_ff))
      else $error("product stage overwritten under stall");

   // a clipped row carries at least one limit value
   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.saturated
      |-> (rsp_if.out_elem0 == ELEM_MAX) || (rsp_if.out_elem0 == ELEM_MIN) ||
          (rsp_if.out_elem1 == ELEM_MAX) || (rsp_if.out_elem1 == ELEM_MIN) ||
          (rsp_if.out_elem2 == ELEM_MAX) || (rsp_if.out_elem2 == ELEM_MIN) ||
          (rsp_if.out_elem3 == ELEM_MAX) || (rsp_if.out_elem3 == ELEM_MIN))
      else $error("saturated flag without a limit value");
`endif

endmodule
